### hw/rtl/two_key_sorted_priority_queue_top_assert.svh
// Assertion macros for the sorted priority queue.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef TWO_KEY_SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define TWO_KEY_SORTED_PRIORITY_QUEUE_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TSKPQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TSKPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/tskpq_pkg.sv
`timescale 1ns / 1ps

package tskpq_pkg;

  // Queue depth and derived widths
  localparam int unsigned Capacity = 16;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned LenW     = 5;

  localparam int unsigned RelW = 4;
  localparam int unsigned DurW = 16;
  localparam int unsigned PayW = 16;

  // Operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic [RelW-1:0] rel;
    logic [DurW-1:0] dur;
    logic [PayW-1:0] pay;
  } entry_t;

  // Broadcast from the top to every cell
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t new_entry;
  } ctrl_t;

  // What a cell shows its neighbors
  typedef struct packed {
    logic   valid;
    logic   shift;
    entry_t entry;
  } link_t;

  // True when entry a sorts at or ahead of entry b (relation, then duration)
  function automatic logic key_le(entry_t a, entry_t b);
    return {a.rel, a.dur} <= {b.rel, b.dur};
  endfunction

endpackage

### hw/rtl/tskpq_cell.sv
`timescale 1ns / 1ps

module tskpq_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tskpq_pkg::ctrl_t ctrl_i,
  input  tskpq_pkg::link_t left_i,
  input  tskpq_pkg::link_t right_i,
  output tskpq_pkg::link_t link_o
);
  import tskpq_pkg::*;

  logic   valid_q, valid_d;
  entry_t entry_q, entry_d;
  logic   shift;

  // A free slot, or one holding an entry not ahead of the new one, makes room
  assign shift = !valid_q || key_le(ctrl_i.new_entry, entry_q);

  // Insert: shift right from the insertion point; remove: shift left
  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (shift) begin
        entry_d = left_i.shift ? left_i.entry : ctrl_i.new_entry;
        valid_d = valid_q | left_i.valid;
      end
    end else if (ctrl_i.rem) begin
      entry_d = right_i.entry;
      valid_d = right_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Entry data carries no reset
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign link_o = '{valid: valid_q, shift: shift, entry: entry_q};

endmodule

### hw/rtl/two_key_sorted_priority_queue_top.sv
`timescale 1ns / 1ps

// Sorted priority queue of call entries, ordered by relation type, then call
// duration, a new entry going ahead of equal ones. It is a row of cells, one
// slot each; on a beat every cell compares its key with the new entry at once
// and shifts right, takes the new entry or holds, and a remove shifts the row
// left. One beat is taken per cycle and its result appears in the next cycle:
// status plus the head entry and the count after that beat. The row's single
// compare-and-shift step sets this rate. A result waiting on out_stall_i holds
// in_stall_o high until it is taken.
module two_key_sorted_priority_queue_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        func_i,
  input  logic [tskpq_pkg::RelW-1:0]  relation_type_i,
  input  logic [tskpq_pkg::DurW-1:0]  call_duration_i,
  input  logic [tskpq_pkg::PayW-1:0]  call_payload_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic                        head_valid_o,
  output logic [tskpq_pkg::RelW-1:0]  head_relation_o,
  output logic [tskpq_pkg::DurW-1:0]  head_duration_o,
  output logic [tskpq_pkg::PayW-1:0]  head_payload_o,
  output logic [tskpq_pkg::LenW-1:0]  queue_length_o
);
  import tskpq_pkg::*;

  link_t             links [Capacity];
  ctrl_t             ctrl;
  logic              accept, full, empty, is_ins, is_rem;
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [CntW-1:0]   count_q, count_d;

  // Accept a beat unless a result is still waiting
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign full   = links[Capacity-1].valid;
  assign empty  = ~links[0].valid;
  assign is_ins = (func_i == FUNC_INSERT);
  assign is_rem = (func_i == FUNC_REMOVE);

  assign ctrl.ins           = accept & is_ins & ~full;
  assign ctrl.rem           = accept & is_rem & ~empty;
  assign ctrl.new_entry.rel = relation_type_i;
  assign ctrl.new_entry.dur = call_duration_i;
  assign ctrl.new_entry.pay = call_payload_i;

  // Row of cells; the ends see a fixed neighbor
  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    link_t left_l, right_l;
    if (i == 0) begin : g_first
      assign left_l = '{valid: 1'b1, shift: 1'b0, entry: '0};
    end else begin : g_mid_l
      assign left_l = links[i-1];
    end
    if (i == Capacity - 1) begin : g_last
      assign right_l = '{valid: 1'b0, shift: 1'b1, entry: '0};
    end else begin : g_mid_r
      assign right_l = links[i+1];
    end
    tskpq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .left_i (left_l),
      .right_i(right_l),
      .link_o (links[i])
    );
  end

  // Status and count for the accepted beat
  always_comb begin
    status_d = status_q;
    count_d  = count_q;
    if (accept) begin
      unique case (func_i)
        FUNC_INSERT: begin
          status_d = full ? ST_FULL : ST_DONE;
          if (!full) count_d = count_q + CntW'(1);
        end
        FUNC_REMOVE: begin
          status_d = empty ? ST_EMPTY : ST_DONE;
          if (!empty) count_d = count_q - CntW'(1);
        end
        default: status_d = ST_DONE;
      endcase
    end
  end

  // Hold a result until taken
  assign out_valid_d = accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      status_q    <= ST_DONE;
      count_q     <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      count_q     <= count_d;
    end
  end

  // Head comes straight from the first cell; the row only moves on accept
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign head_valid_o    = links[0].valid;
  assign head_relation_o = links[0].valid ? links[0].entry.rel : '0;
  assign head_duration_o = links[0].valid ? links[0].entry.dur : '0;
  assign head_payload_o  = links[0].valid ? links[0].entry.pay : '0;
  assign queue_length_o  = LenW'(count_q);

`include "two_key_sorted_priority_queue_top_assert.svh"

  `TSKPQ_ASSERT_NOW(a_head_matches_count, 1'b1, (count_q != '0) == links[0].valid, "head valid disagrees with count")
  `TSKPQ_ASSERT_NOW(a_full_matches_count, 1'b1, (count_q == CntW'(Capacity)) == full, "last cell disagrees with count")
  `TSKPQ_ASSERT_NEXT(a_insert_grows, ctrl.ins, count_q == $past(count_q) + CntW'(1), "insert did not grow count")
  `TSKPQ_ASSERT_NEXT(a_refused_holds, accept && status_d != ST_DONE, $stable(count_q), "refused beat changed count")

endmodule
